FILE: rtl/core/clq_pkg.sv
// ----------------------------------------------------------------------------
// clq_pkg: shared types and constants of the command line queue decoder
// Holds the keyword table, the status and command codes and the control
// structs that pass between the top level and the line assembler.
// ----------------------------------------------------------------------------
package clq_pkg;

	localparam int unsigned KW_COUNT  = 8;
	localparam int unsigned KW_MAXLEN = 12;

	// Keywords in priority order; command code is the index plus one.
	// Each keyword is right-aligned, its last character in the low byte.
	localparam logic [8*KW_MAXLEN-1:0] KW_TEXT [KW_COUNT] = '{
		{"led_all", "_on"}, {"led_all", "_off"}, {"led_on", "_down"}, {"led_on", "_up"},
		{"keepon", "_up"}, {"keepon", "_down"}, {"flower", "_on"}, {"flower", "_off"}
	};
	localparam int unsigned KW_LEN [KW_COUNT] = '{10, 11, 11, 9, 9, 11, 9, 10};

	localparam logic [7:0] CHAR_LF = 8'h0A;
	localparam logic [7:0] CHAR_CR = 8'h0D;

	localparam logic REQ_BYTE    = 1'b0;
	localparam logic REQ_DEQUEUE = 1'b1;

	localparam logic [2:0] ST_STORED   = 3'd0;
	localparam logic [2:0] ST_QUEUED   = 3'd1;
	localparam logic [2:0] ST_FULL     = 3'd2;
	localparam logic [2:0] ST_TOO_LONG = 3'd3;
	localparam logic [2:0] ST_ISSUED   = 3'd4;
	localparam logic [2:0] ST_EMPTY    = 3'd5;

	localparam logic [3:0] CMD_NONE    = 4'd0;
	localparam logic [3:0] CMD_UNKNOWN = 4'd9;

	// Control from the top level to the line assembler.
	typedef struct packed {
		logic track;  // Compare and count one ordinary character.
		logic clear;  // Start a new line.
	} asm_ctl_t;

	// Status from the line assembler to the top level.
	typedef struct packed {
		logic       at_limit;  // The current line has reached the length limit.
		logic [3:0] code;      // Command code of the line as received so far.
	} asm_stat_t;

	// Character at position pos of keyword k; zero past the end of the keyword.
	function automatic logic [7:0] kw_char(input int unsigned k, input int unsigned pos);
		logic [7:0] ch;
		ch = 8'h00;
		if (pos < KW_LEN[k]) begin
			ch = KW_TEXT[k][8*(KW_LEN[k]-1-pos) +: 8];
		end
		return ch;
	endfunction

endpackage

FILE: rtl/core/clq_in_if.sv
// ----------------------------------------------------------------------------
// clq_in_if: request channel of the command line queue decoder
// Carries a received byte or a dequeue request under a valid/ready handshake.
// ----------------------------------------------------------------------------
interface clq_in_if;
	logic       valid;
	logic       ready;
	logic       req_type;
	logic [7:0] rx_byte;

	modport source (output valid, output req_type, output rx_byte, input ready);
	modport sink   (input valid, input req_type, input rx_byte, output ready);
endinterface

FILE: rtl/core/clq_out_if.sv
// ----------------------------------------------------------------------------
// clq_out_if: result channel of the command line queue decoder
// Carries status, command code and queue slot under a valid/ready handshake.
// ----------------------------------------------------------------------------
interface clq_out_if;
	logic       valid;
	logic       ready;
	logic [2:0] status;
	logic [3:0] command;
	logic [3:0] slot;

	modport source (output valid, output status, output command, output slot, input ready);
	modport sink   (input valid, input status, input command, input slot, output ready);
endinterface

FILE: rtl/core/clq_ram.sv
// ----------------------------------------------------------------------------
// clq_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module clq_ram #(
	parameter int unsigned WIDTH = 4,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: rtl/core/clq_line_asm.sv
// ----------------------------------------------------------------------------
// clq_line_asm: line assembler and keyword tracker
// Counts characters of the current line and keeps one match flag per keyword.
// ----------------------------------------------------------------------------
module clq_line_asm #(
	parameter int unsigned LINE_LIMIT = 40
) (
	input  logic               clk,
	input  logic               arst_n,
	input  clq_pkg::asm_ctl_t  ctl,
	input  logic [7:0]         rx_byte,
	output clq_pkg::asm_stat_t stat
);

	localparam int unsigned PosW = $clog2(LINE_LIMIT + 1);

	logic [PosW-1:0]              pos_q;
	logic [clq_pkg::KW_COUNT-1:0] flags_q;
	logic [clq_pkg::KW_COUNT-1:0] flags_nxt;
	logic [3:0]                   code;

	// A keyword drops out at the first character that differs from it.
	always_comb begin
		flags_nxt = flags_q;
		for (int unsigned k = 0; k < clq_pkg::KW_COUNT; k++) begin
			if ((int'(pos_q) < clq_pkg::KW_LEN[k]) &&
			    (rx_byte != clq_pkg::kw_char(k, int'(pos_q)))) begin
				flags_nxt[k] = 1'b0;
			end
		end
	end

	// First keyword still matching whose full length has been received.
	always_comb begin
		code = clq_pkg::CMD_UNKNOWN;
		for (int k = clq_pkg::KW_COUNT - 1; k >= 0; k--) begin
			if (flags_q[k] && (int'(pos_q) >= clq_pkg::KW_LEN[k])) begin
				code = 4'(k + 1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			flags_q <= '1;
		end else if (ctl.clear) begin
			pos_q   <= '0;
			flags_q <= '1;
		end else if (ctl.track) begin
			pos_q   <= pos_q + PosW'(1);
			flags_q <= flags_nxt;
		end
	end

	assign stat.at_limit = (pos_q >= PosW'(LINE_LIMIT));
	assign stat.code     = code;

endmodule

FILE: rtl/core/command_line_queue_decoder.sv
// ----------------------------------------------------------------------------
// command_line_queue_decoder: line queue with keyword command decoder
// A byte item gives its result in the output register in the cycle after it
// is accepted; a dequeue of a non-empty queue passes through READ for the
// registered read of the queue RAM. Byte items are taken one per cycle while
// the output register is free or being emptied; a dequeue of a non-empty
// queue holds the input while the queue RAM read completes.
// Reset clears the pointers, the line length and the match flags at once;
// the queue RAM is not cleared, as no slot is read before it is written.
// ----------------------------------------------------------------------------
module command_line_queue_decoder #(
	parameter int unsigned QUEUE_DEPTH = 16,
	parameter int unsigned LINE_LIMIT  = 40
) (
	input logic     clk,
	input logic     arst_n,
	clq_in_if.sink  req,
	clq_out_if.source rsp
);

	localparam int unsigned PtrW = $clog2(QUEUE_DEPTH);

	// Two-state sequencer: IDLE takes items, READ waits for the queue RAM.
	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_READ = 2'b10
	} state_t;

	state_t state_q;

	logic [PtrW-1:0] wp_q;
	logic [PtrW-1:0] rp_q;
	logic [PtrW-1:0] wp_nxt;
	logic [PtrW-1:0] rp_nxt;

	logic       out_valid_q;
	logic [2:0] status_q;
	logic [3:0] command_q;
	logic [3:0] slot_q;

	logic accept;
	logic is_byte;
	logic is_eol;
	logic q_full;
	logic q_empty;
	logic deq_read;
	logic line_write;
	logic [2:0] byte_status;
	logic [3:0] ram_rdata;
	logic [PtrW+3:0] wp_ext;
	logic [PtrW+3:0] rp_ext;

	clq_pkg::asm_ctl_t  asm_ctl;
	clq_pkg::asm_stat_t asm_stat;

	// The pointers wrap at the queue depth, which need not be a power of two.
	assign wp_nxt = (wp_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wp_q + PtrW'(1);
	assign rp_nxt = (rp_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rp_q + PtrW'(1);

	// One slot is always left free, so full means the writer is one behind the reader.
	assign q_full  = (wp_nxt == rp_q);
	assign q_empty = (wp_q == rp_q);

	// An item is taken only when the sequencer is idle and the output register
	// is free or is being emptied in the same cycle.
	assign req.ready = (state_q == S_IDLE) && (!out_valid_q || rsp.ready);
	assign accept    = req.valid && req.ready;
	assign is_byte   = (req.req_type == clq_pkg::REQ_BYTE);
	assign is_eol    = (req.rx_byte == clq_pkg::CHAR_LF) || (req.rx_byte == clq_pkg::CHAR_CR);

	// A full queue drops every byte, CR and LF included, and leaves the line
	// as it was. Otherwise a line at the limit is discarded, and a CR or LF
	// closes the line and writes its command code into the queue.
	always_comb begin
		if (q_full) begin
			byte_status = clq_pkg::ST_FULL;
		end else if (asm_stat.at_limit) begin
			byte_status = clq_pkg::ST_TOO_LONG;
		end else if (is_eol) begin
			byte_status = clq_pkg::ST_QUEUED;
		end else begin
			byte_status = clq_pkg::ST_STORED;
		end
	end

	assign asm_ctl.track = accept && is_byte && (byte_status == clq_pkg::ST_STORED);
	assign asm_ctl.clear = accept && is_byte &&
	                       ((byte_status == clq_pkg::ST_TOO_LONG) ||
	                        (byte_status == clq_pkg::ST_QUEUED));
	assign line_write    = accept && is_byte && (byte_status == clq_pkg::ST_QUEUED);
	assign deq_read      = accept && !is_byte && !q_empty;

	clq_line_asm #(
		.LINE_LIMIT (LINE_LIMIT)
	) u_line_asm (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (asm_ctl),
		.rx_byte (req.rx_byte),
		.stat    (asm_stat)
	);

	// The queue itself: one command code per slot.
	clq_ram #(
		.WIDTH (4),
		.DEPTH (QUEUE_DEPTH)
	) u_queue_ram (
		.clk   (clk),
		.we    (line_write),
		.waddr (wp_q),
		.wdata (asm_stat.code),
		.re    (deq_read),
		.raddr (rp_q),
		.rdata (ram_rdata)
	);

	// The slot field reports the low four bits of the pointer concerned.
	assign wp_ext = {4'b0000, wp_q};
	assign rp_ext = {4'b0000, rp_q};

	// Sequencer, pointers and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			wp_q        <= '0;
			rp_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (deq_read) begin
						state_q     <= S_READ;
						rp_q        <= rp_nxt;
						out_valid_q <= 1'b0;
					end else if (accept) begin
						out_valid_q <= 1'b1;
						if (line_write) begin
							wp_q <= wp_nxt;
						end
					end else if (rsp.ready) begin
						out_valid_q <= 1'b0;
					end
				end
				S_READ: begin
					// The RAM data of the dequeued slot is valid in this cycle.
					state_q     <= S_IDLE;
					out_valid_q <= 1'b1;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Result payload. A dequeue of a non-empty queue sets status and slot when
	// it is taken and picks up the command code from the RAM in READ.
	always_ff @(posedge clk) begin
		if (accept) begin
			if (is_byte) begin
				status_q  <= byte_status;
				command_q <= clq_pkg::CMD_NONE;
				slot_q    <= wp_ext[3:0];
			end else if (q_empty) begin
				status_q  <= clq_pkg::ST_EMPTY;
				command_q <= clq_pkg::CMD_NONE;
				slot_q    <= rp_ext[3:0];
			end else begin
				status_q  <= clq_pkg::ST_ISSUED;
				command_q <= clq_pkg::CMD_NONE;
				slot_q    <= rp_ext[3:0];
			end
		end else if (state_q == S_READ) begin
			command_q <= ram_rdata;
		end
	end

	assign rsp.valid   = out_valid_q;
	assign rsp.status  = status_q;
	assign rsp.command = command_q;
	assign rsp.slot    = slot_q;

`ifndef ASSERT_OFF
	// A dequeue of a non-empty queue always goes through the RAM read cycle.
	a_deq_reads: assert property (@(posedge clk) disable iff (!arst_n)
		deq_read |=> (state_q == S_READ))
		else $error("dequeue did not enter the read cycle");

	// The output register is free while the RAM read is pending.
	a_read_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_READ) |-> !out_valid_q)
		else $error("output register busy during queue read");

	// Only an issued command carries a command code.
	a_cmd_only_issued: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (status_q != clq_pkg::ST_ISSUED)) |-> (command_q == clq_pkg::CMD_NONE))
		else $error("command code on a result that is not an issued command");

	// After a line is queued the queue cannot be empty.
	a_queued_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		line_write |=> (wp_q != rp_q))
		else $error("queue empty right after a line was queued");

	// Nothing is written into a full queue.
	a_no_write_full: assert property (@(posedge clk) disable iff (!arst_n)
		line_write |-> !q_full)
		else $error("line written into a full queue");
`endif

endmodule
